// ----- rtl/core/i2cm_pkg.sv -----
package i2cm_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;

  localparam int unsigned UNIT_W  = 10;
  localparam int unsigned DELAY_W = 12;
  localparam int unsigned POLL_W  = 10;

  localparam logic [UNIT_W-1:0] TICKS_RESET = 10'd50;
  localparam logic [POLL_W-1:0] POLL_RESET  = 10'd250;

  // configuration register indexes
  localparam logic CFG_TICKS_PER_UNIT = 1'b0;
  localparam logic CFG_ACK_POLL_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_WACK  = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_ST_A    = 5'd1,
    PH_ST_B    = 5'd2,
    PH_SP_A    = 5'd3,
    PH_SP_B    = 5'd4,
    PH_WA_A    = 5'd5,
    PH_WA_POLL = 5'd6,
    PH_WB_HI   = 5'd7,
    PH_WB_LO   = 5'd8,
    PH_WB_NEXT = 5'd9,
    PH_RB_HI   = 5'd10,
    PH_RB_NEXT = 5'd11,
    PH_RA_HI   = 5'd12,
    PH_RA_END  = 5'd13
  } phase_e;

  typedef struct packed {
    phase_e             phase;
    logic [2:0]         command_kind;
    logic [3:0]         bit_count;
    logic [7:0]         shift_reg;
    logic [DELAY_W-1:0] delay_count;
    logic [POLL_W-1:0]  poll_count;
    logic               scl_reg;
    logic               sda_reg;
    logic               sda_dir;
    logic               ack_choice;
    logic               fail_flag;
    logic [7:0]         rx_hold;
  } state_t;

  typedef struct packed {
    logic       req_valid;
    logic [2:0] req_type;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic [UNIT_W-1:0] ticks_per_unit;
    logic [POLL_W-1:0] ack_poll_limit;
  } cfg_t;

endpackage

// ----- rtl/core/i2cm_step.sv -----
module i2cm_step #(
  parameter int unsigned BITS_PER_BYTE = i2cm_pkg::BITS_PER_BYTE
) (
  input  i2cm_pkg::state_t state_i,
  input  i2cm_pkg::req_t   req_i,
  input  i2cm_pkg::cfg_t   cfg_i,
  output i2cm_pkg::state_t state_o,
  output logic             done_o
);
  import i2cm_pkg::*;

  localparam logic [3:0] NumBits = 4'(BITS_PER_BYTE);

  logic [UNIT_W-1:0]  unit_eff;
  logic [DELAY_W-1:0] d1, d2, dc;
  logic [POLL_W:0]    poll_inc;

  assign unit_eff = (cfg_i.ticks_per_unit == '0) ? UNIT_W'(1) : cfg_i.ticks_per_unit;
  assign d1       = DELAY_W'(unit_eff);
  assign d2       = DELAY_W'({unit_eff, 1'b0});
  assign poll_inc = {1'b0, state_i.poll_count} + (POLL_W+1)'(1);

  always_comb begin
    state_o = state_i;
    done_o  = 1'b0;
    dc      = state_i.delay_count;
    if (state_i.phase == PH_IDLE) begin
      if (req_i.req_valid) begin
        unique case (req_i.req_type)
          CMD_START: begin
            state_o.command_kind = req_i.req_type;
            state_o.sda_dir      = 1'b1;
            state_o.sda_reg      = 1'b1;
            state_o.scl_reg      = 1'b1;
            state_o.delay_count  = d2;
            state_o.phase        = PH_ST_A;
          end
          CMD_STOP: begin
            state_o.command_kind = req_i.req_type;
            state_o.sda_dir      = 1'b1;
            state_o.scl_reg      = 1'b0;
            state_o.sda_reg      = 1'b0;
            state_o.delay_count  = d2;
            state_o.phase        = PH_SP_A;
          end
          CMD_WRITE: begin
            state_o.command_kind = req_i.req_type;
            state_o.sda_dir      = 1'b1;
            state_o.scl_reg      = 1'b0;
            state_o.bit_count    = '0;
            state_o.sda_reg      = req_i.tx_byte[7];
            state_o.shift_reg    = {req_i.tx_byte[6:0], 1'b0};
            state_o.delay_count  = d1;
            state_o.phase        = PH_WB_HI;
          end
          CMD_WACK: begin
            state_o.command_kind = req_i.req_type;
            state_o.fail_flag    = 1'b0;
            state_o.poll_count   = '0;
            state_o.sda_dir      = 1'b0;
            state_o.sda_reg      = 1'b1;
            state_o.delay_count  = d1;
            state_o.phase        = PH_WA_A;
          end
          CMD_READ: begin
            state_o.command_kind = req_i.req_type;
            state_o.sda_dir      = 1'b0;
            state_o.sda_reg      = 1'b1;
            state_o.scl_reg      = 1'b0;
            state_o.bit_count    = '0;
            state_o.shift_reg    = '0;
            state_o.ack_choice   = req_i.send_ack;
            state_o.delay_count  = d1;
            state_o.phase        = PH_RB_HI;
          end
          default: ;  // unknown codes leave the block idle
        endcase
      end
    end else begin
      if (dc != '0) dc = dc - DELAY_W'(1);
      state_o.delay_count = dc;
      if (dc == '0) begin
        unique case (state_i.phase)
          PH_ST_A: begin
            state_o.sda_reg     = 1'b0;
            state_o.delay_count = d2;
            state_o.phase       = PH_ST_B;
          end
          PH_ST_B: begin
            state_o.scl_reg = 1'b0;
            done_o          = 1'b1;
          end
          PH_SP_A: begin
            state_o.scl_reg     = 1'b1;
            state_o.sda_reg     = 1'b1;
            state_o.delay_count = d2;
            state_o.phase       = PH_SP_B;
          end
          PH_SP_B: done_o = 1'b1;
          PH_WA_A: begin
            state_o.scl_reg     = 1'b1;
            state_o.delay_count = d1;
            state_o.phase       = PH_WA_POLL;
          end
          PH_WA_POLL: begin
            if (!req_i.sda_in) begin
              state_o.scl_reg = 1'b0;
              done_o          = 1'b1;
            end else if (poll_inc > {1'b0, cfg_i.ack_poll_limit}) begin
              // timed out: flag it and run the stop sequence
              state_o.fail_flag   = 1'b1;
              state_o.sda_dir     = 1'b1;
              state_o.scl_reg     = 1'b0;
              state_o.sda_reg     = 1'b0;
              state_o.delay_count = d2;
              state_o.phase       = PH_SP_A;
            end else begin
              state_o.poll_count  = poll_inc[POLL_W-1:0];
              state_o.delay_count = DELAY_W'(1);
            end
          end
          PH_WB_HI: begin
            state_o.scl_reg     = 1'b1;
            state_o.delay_count = d1;
            state_o.phase       = PH_WB_LO;
          end
          PH_WB_LO: begin
            state_o.scl_reg     = 1'b0;
            state_o.delay_count = d1;
            state_o.phase       = PH_WB_NEXT;
          end
          PH_WB_NEXT: begin
            state_o.bit_count = state_i.bit_count + 4'd1;
            if (state_o.bit_count >= NumBits) begin
              done_o = 1'b1;
            end else begin
              state_o.sda_reg     = state_i.shift_reg[7];
              state_o.shift_reg   = {state_i.shift_reg[6:0], 1'b0};
              state_o.delay_count = d1;
              state_o.phase       = PH_WB_HI;
            end
          end
          PH_RB_HI: begin
            state_o.scl_reg     = 1'b1;
            state_o.shift_reg   = {state_i.shift_reg[6:0], req_i.sda_in};
            state_o.delay_count = d1;
            state_o.phase       = PH_RB_NEXT;
          end
          PH_RB_NEXT: begin
            state_o.bit_count = state_i.bit_count + 4'd1;
            state_o.scl_reg   = 1'b0;
            if (state_o.bit_count < NumBits) begin
              state_o.delay_count = d1;
              state_o.phase       = PH_RB_HI;
            end else begin
              state_o.rx_hold     = state_i.shift_reg;
              state_o.sda_dir     = 1'b1;
              state_o.sda_reg     = ~state_i.ack_choice;
              state_o.delay_count = d2;
              state_o.phase       = PH_RA_HI;
            end
          end
          PH_RA_HI: begin
            state_o.scl_reg     = 1'b1;
            state_o.delay_count = d2;
            state_o.phase       = PH_RA_END;
          end
          PH_RA_END: begin
            state_o.scl_reg = 1'b0;
            done_o          = 1'b1;
          end
          default: done_o = 1'b1;
        endcase
        if (done_o) begin
          state_o.phase       = PH_IDLE;
          state_o.delay_count = '0;
        end
      end
    end
  end

endmodule

// ----- rtl/core/i2c_master_bit_engine_top.sv -----
// I2C master bit engine. Each input item is one bus timing tick carrying the
// sampled SDA level and an optional command (start, stop, write byte MSB
// first, wait for acknowledge, read byte with ACK or NACK). Every accepted
// item yields exactly one result item with the SCL/SDA drive levels and the
// command status after that tick. One item is taken per clock cycle; the
// tick's state update is a single combinational pass into the state and
// result registers, and the result register only holds the input off while
// a result is waiting and the output side stalls. Bus delays are one or two
// units of ticks_per_unit ticks (0 acts as 1). Commands offered while
// busy, or on the tick a command finishes, are ignored. Configuration is
// written through the cfg port, index 0 ticks_per_unit, index 1
// ack_poll_limit, and is always ready.
module i2c_master_bit_engine_top #(
  parameter int unsigned BITS_PER_BYTE = i2cm_pkg::BITS_PER_BYTE
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] req_valid, [8:1] tx_byte, [9] send_ack, [10] sda_in, [15:11] zero
  input  logic [15:0] s_axis_tdata,
  // [2:0] req_type
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res, [4] done_res,
  // [12:5] rx_byte, [13] ack_failed, [15:14] zero
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [9:0]  cfg_data_i
);
  import i2cm_pkg::*;

  state_t state_q, state_d;
  cfg_t   cfg_q;
  req_t   req;
  logic   done;
  logic   in_fire;
  logic   out_valid_q;
  logic [15:0] out_data_q;

  assign req.req_valid = s_axis_tdata[0];
  assign req.tx_byte   = s_axis_tdata[8:1];
  assign req.send_ack  = s_axis_tdata[9];
  assign req.sda_in    = s_axis_tdata[10];
  assign req.req_type  = s_axis_tuser;

  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  i2cm_step #(
    .BITS_PER_BYTE(BITS_PER_BYTE)
  ) u_step (
    .state_i(state_q),
    .req_i  (req),
    .cfg_i  (cfg_q),
    .state_o(state_d),
    .done_o (done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_unit <= TICKS_RESET;
      cfg_q.ack_poll_limit <= POLL_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TICKS_PER_UNIT: cfg_q.ticks_per_unit <= cfg_data_i;
        CFG_ACK_POLL_LIMIT: cfg_q.ack_poll_limit <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, scl_reg: 1'b1, sda_reg: 1'b1, sda_dir: 1'b1,
                   default: '0};
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // hold the result until taken; load a fresh one with each accepted item
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= {2'b00, state_d.fail_flag, state_d.rx_hold, done,
                     (state_d.phase != PH_IDLE), state_d.sda_dir,
                     state_d.sda_reg, state_d.scl_reg};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- bench/i2c_master_bit_engine_top_tb.sv -----
module i2c_master_bit_engine_top_tb;
  import i2cm_pkg::*;

  localparam int unsigned MAX_SHOWN = 10;
  localparam int unsigned LONG_HOLD = 60;
  localparam int unsigned HALF_PERIOD = 10;
  localparam int unsigned RUN_LIMIT = 20 * 1000000;

  // codes outside the command set, ignored by the block
  localparam logic [2:0] CODE_BAD_LO = 3'd5;
  localparam logic [2:0] CODE_BAD_HI = 3'd7;

  typedef enum logic [1:0] {
    SDA_NOISE,
    SDA_HIGH,
    SDA_MOSTLY_HIGH,
    SDA_LOW
  } sda_mode_e;

  // laid out as m_axis_tdata[13:0]
  typedef struct packed {
    logic       ack_failed;
    logic [7:0] rx_byte;
    logic       done;
    logic       busy;
    logic       sda_drive;
    logic       sda_level;
    logic       scl_level;
  } levels_t;

  localparam levels_t BUS_IDLE_LEVELS = '{ack_failed: 1'b0, rx_byte: 8'h00, done: 1'b0,
                                           busy: 1'b0, sda_drive: 1'b1, sda_level: 1'b1,
                                           scl_level: 1'b1};

  typedef struct {
    bit          is_cfg;
    logic        cfg_idx;
    logic [9:0]  cfg_val;
    req_t        rq;
    int unsigned idle_after;
    bit          typed;
    levels_t     want;
  } dir_row_t;

  typedef struct {
    logic [9:0]  unit;
    logic [9:0]  limit;
    int unsigned ticks;
    bit          force_start;
  } run_plan_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [9:0]  cfg_data_i;

  // bus engine mirror
  logic [9:0]  unit_ticks;
  logic [9:0]  poll_limit;
  phase_e      bus_phase;
  logic [11:0] delay_left;
  logic [3:0]  bit_idx;
  logic [7:0]  shift_byte;
  logic [7:0]  rx_last;
  logic [9:0]  poll_cnt;
  logic        scl_q;
  logic        sda_q;
  logic        sda_oe_q;
  logic        ack_sel_q;
  logic        ack_timeout_q;

  levels_t     expected_levels[$];
  dir_row_t    dir_rows[$];
  run_plan_t   plans[$];

  cmd_e        last_cmd = CMD_STOP;
  sda_mode_e   sda_mode = SDA_NOISE;
  bit          send_gaps = 1'b1;
  bit          long_hold_req = 1'b0;
  int unsigned mismatch_cnt = 0;
  int unsigned results_seen = 0;
  int unsigned ticks_sent = 0;
  int unsigned cmds_taken = 0;
  int unsigned reads_done = 0;
  int unsigned timeouts_seen = 0;

  i2c_master_bit_engine_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  task automatic delay_units(input int unsigned units, input phase_e nxt);
    logic [9:0] u;
    u = (unit_ticks == 10'd0) ? 10'd1 : unit_ticks;
    delay_left = 12'(units * 32'(u));
    bus_phase = nxt;
  endtask

  task automatic shift_out();
    sda_q = shift_byte[7];
    shift_byte = {shift_byte[6:0], 1'b0};
  endtask

  task automatic stop_seq();
    sda_oe_q = 1'b1;
    scl_q = 1'b0;
    sda_q = 1'b0;
    delay_units(2, PH_SP_A);
  endtask

  task automatic take_cmd(input cmd_e kind, input logic [7:0] tx, input logic ack);
    cmds_taken++;
    case (kind)
      CMD_START: begin
        sda_oe_q = 1'b1;
        sda_q = 1'b1;
        scl_q = 1'b1;
        delay_units(2, PH_ST_A);
      end
      CMD_STOP: stop_seq();
      CMD_WRITE: begin
        sda_oe_q = 1'b1;
        scl_q = 1'b0;
        bit_idx = 4'd0;
        shift_byte = tx;
        shift_out();
        delay_units(1, PH_WB_HI);
      end
      CMD_WACK: begin
        ack_timeout_q = 1'b0;
        poll_cnt = 10'd0;
        sda_oe_q = 1'b0;
        sda_q = 1'b1;
        delay_units(1, PH_WA_A);
      end
      default: begin
        sda_oe_q = 1'b0;
        sda_q = 1'b1;
        scl_q = 1'b0;
        bit_idx = 4'd0;
        shift_byte = 8'h00;
        ack_sel_q = ack;
        delay_units(1, PH_RB_HI);
      end
    endcase
  endtask

  // action due once the running delay has expired
  task automatic bus_action(input logic sda_in, output logic fin);
    fin = 1'b0;
    case (bus_phase)
      PH_ST_A: begin
        sda_q = 1'b0;
        delay_units(2, PH_ST_B);
      end
      PH_ST_B: begin
        scl_q = 1'b0;
        fin = 1'b1;
      end
      PH_SP_A: begin
        scl_q = 1'b1;
        sda_q = 1'b1;
        delay_units(2, PH_SP_B);
      end
      PH_SP_B: fin = 1'b1;
      PH_WA_A: begin
        scl_q = 1'b1;
        delay_units(1, PH_WA_POLL);
      end
      PH_WA_POLL: begin
        if (!sda_in) begin
          scl_q = 1'b0;
          fin = 1'b1;
        end else if ({1'b0, poll_cnt} + 11'd1 > {1'b0, poll_limit}) begin
          ack_timeout_q = 1'b1;
          timeouts_seen++;
          stop_seq();
        end else begin
          poll_cnt = poll_cnt + 10'd1;
          delay_left = 12'd1;
        end
      end
      PH_WB_HI: begin
        scl_q = 1'b1;
        delay_units(1, PH_WB_LO);
      end
      PH_WB_LO: begin
        scl_q = 1'b0;
        delay_units(1, PH_WB_NEXT);
      end
      PH_WB_NEXT: begin
        bit_idx = bit_idx + 4'd1;
        if (32'(bit_idx) >= BITS_PER_BYTE) begin
          fin = 1'b1;
        end else begin
          shift_out();
          delay_units(1, PH_WB_HI);
        end
      end
      PH_RB_HI: begin
        scl_q = 1'b1;
        shift_byte = {shift_byte[6:0], sda_in};
        delay_units(1, PH_RB_NEXT);
      end
      PH_RB_NEXT: begin
        bit_idx = bit_idx + 4'd1;
        scl_q = 1'b0;
        if (32'(bit_idx) < BITS_PER_BYTE) begin
          delay_units(1, PH_RB_HI);
        end else begin
          rx_last = shift_byte;
          reads_done++;
          sda_oe_q = 1'b1;
          sda_q = ~ack_sel_q;
          delay_units(2, PH_RA_HI);
        end
      end
      PH_RA_HI: begin
        scl_q = 1'b1;
        delay_units(2, PH_RA_END);
      end
      PH_RA_END: begin
        scl_q = 1'b0;
        fin = 1'b1;
      end
      default: fin = 1'b1;
    endcase
  endtask

  task automatic tick_engine(input req_t rq, output levels_t lv);
    logic fin;
    fin = 1'b0;
    if (bus_phase == PH_IDLE) begin
      if (rq.req_valid && rq.req_type <= CMD_READ)
        take_cmd(cmd_e'(rq.req_type), rq.tx_byte, rq.send_ack);
    end else begin
      if (delay_left != 12'd0) delay_left = delay_left - 12'd1;
      if (delay_left == 12'd0) begin
        bus_action(rq.sda_in, fin);
        if (fin) begin
          bus_phase = PH_IDLE;
          delay_left = 12'd0;
        end
      end
    end
    lv.scl_level  = scl_q;
    lv.sda_level  = sda_q;
    lv.sda_drive  = sda_oe_q;
    lv.busy       = (bus_phase != PH_IDLE);
    lv.done       = fin;
    lv.rx_byte    = rx_last;
    lv.ack_failed = ack_timeout_q;
  endtask

  function automatic cmd_e next_command();
    int unsigned p;
    p = $urandom_range(0, 99);
    case (last_cmd)
      CMD_START: next_command = CMD_WRITE;
      CMD_WRITE: next_command = CMD_WACK;
      CMD_WACK: begin
        // a timed-out acknowledge has already put a stop on the bus
        if (ack_timeout_q)  next_command = CMD_START;
        else if (p < 40)    next_command = CMD_WRITE;
        else if (p < 70)    next_command = CMD_READ;
        else if (p < 90)    next_command = CMD_STOP;
        else                next_command = CMD_START;
      end
      CMD_READ: begin
        if (p < 50)         next_command = CMD_READ;
        else if (p < 90)    next_command = CMD_STOP;
        else                next_command = CMD_START;
      end
      default: next_command = CMD_START;
    endcase
  endfunction

  task automatic draw_tick(input bit force_start, output req_t rq);
    int unsigned pick;
    rq.req_valid = 1'b0;
    rq.req_type  = 3'($urandom_range(0, 7));
    rq.tx_byte   = 8'($urandom_range(0, 255));
    rq.send_ack  = 1'($urandom_range(0, 1));
    pick = force_start ? 0 : $urandom_range(0, 99);
    if (bus_phase != PH_IDLE) begin
      // offered while busy, so ignored
      rq.req_valid = (pick < 25);
    end else if (pick >= 70 && pick < 80) begin
      rq.req_valid = 1'b1;
      rq.req_type  = 3'($urandom_range(CODE_BAD_LO, CODE_BAD_HI));
    end else if (pick < 88) begin
      rq.req_valid = 1'b1;
      if (force_start)   rq.req_type = CMD_START;
      else if (pick < 70) rq.req_type = next_command();
      else               rq.req_type = 3'($urandom_range(CMD_START, CMD_READ));
      last_cmd = cmd_e'(rq.req_type);
      sda_mode = sda_mode_e'($urandom_range(0, 3));
    end
    case (sda_mode)
      SDA_NOISE:       rq.sda_in = 1'($urandom_range(0, 1));
      SDA_HIGH:        rq.sda_in = 1'b1;
      SDA_MOSTLY_HIGH: rq.sda_in = ($urandom_range(0, 9) != 0);
      default:         rq.sda_in = 1'b0;
    endcase
  endtask

  task automatic push_item(input req_t rq, input bit typed, input levels_t want);
    int unsigned gap;
    levels_t lv;
    gap = send_gaps ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, rq.sda_in, rq.send_ack, rq.tx_byte, rq.req_valid};
    s_axis_tuser  <= rq.req_type;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    tick_engine(rq, lv);
    expected_levels.push_back(typed ? want : lv);
    ticks_sent++;
  endtask

  // drop valid and wait until every expected item has come back
  task automatic settle_bus();
    s_axis_tvalid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [9:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    cfg_valid_i <= 1'b0;
    if (idx == CFG_TICKS_PER_UNIT) unit_ticks = val;
    else poll_limit = val;
  endtask

  task automatic check_levels(input levels_t got);
    levels_t want;
    bit bad;
    if (expected_levels.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= MAX_SHOWN)
        $display("result item %h arrived with nothing expected", got);
    end else begin
      want = expected_levels.pop_front();
      results_seen++;
      bad = (got.scl_level !== want.scl_level) || (got.sda_level !== want.sda_level) ||
            (got.sda_drive !== want.sda_drive) || (got.busy !== want.busy) ||
            (got.done !== want.done) || (got.rx_byte !== want.rx_byte) ||
            (got.ack_failed !== want.ack_failed);
      if (bad) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_SHOWN) begin
          $display("item %0d: expected scl %b sda %b drive %b busy %b done %b rx %h fail %b",
                   results_seen, want.scl_level, want.sda_level, want.sda_drive, want.busy,
                   want.done, want.rx_byte, want.ack_failed);
          $display("item %0d:   actual scl %b sda %b drive %b busy %b done %b rx %h fail %b",
                   results_seen, got.scl_level, got.sda_level, got.sda_drive, got.busy,
                   got.done, got.rx_byte, got.ack_failed);
        end
      end
    end
  endtask

  function automatic dir_row_t cmd_row(input bit valid, input logic [2:0] kind,
                                       input logic [7:0] tx, input bit ack, input bit sda,
                                       input int unsigned idle_after);
    cmd_row.is_cfg       = 1'b0;
    cmd_row.cfg_idx      = CFG_TICKS_PER_UNIT;
    cmd_row.cfg_val      = 10'd0;
    cmd_row.rq.req_valid = valid;
    cmd_row.rq.req_type  = kind;
    cmd_row.rq.tx_byte   = tx;
    cmd_row.rq.send_ack  = ack;
    cmd_row.rq.sda_in    = sda;
    cmd_row.idle_after   = idle_after;
    cmd_row.typed        = 1'b0;
    cmd_row.want         = BUS_IDLE_LEVELS;
  endfunction

  function automatic dir_row_t cfg_row(input logic idx, input logic [9:0] val);
    cfg_row = cmd_row(1'b0, CMD_START, 8'h00, 1'b0, 1'b0, 0);
    cfg_row.is_cfg  = 1'b1;
    cfg_row.cfg_idx = idx;
    cfg_row.cfg_val = val;
  endfunction

  // receiver: draws a stall per item, honours one long hold-off on request
  initial begin
    int unsigned stall;
    int unsigned taken;
    bit rx_gaps;
    stall = 0;
    taken = 0;
    rx_gaps = 1'b1;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        check_levels(levels_t'(m_axis_tdata[13:0]));
        taken++;
        if (taken % 50 == 0) rx_gaps = ($urandom_range(0, 3) != 0);
        stall = rx_gaps ? $urandom_range(0, 4) : 0;
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = LONG_HOLD;
      end
      if (stall != 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    #(RUN_LIMIT);
    $display("Run stopped by the watchdog");
    $display("Mismatches found");
    $finish;
  end

  initial begin
    req_t rq;
    req_t filler;
    dir_row_t row;
    int unsigned n;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 16'd0;
    s_axis_tuser  = 3'd0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_TICKS_PER_UNIT;
    cfg_data_i    = 10'd0;

    unit_ticks    = TICKS_RESET;
    poll_limit    = POLL_RESET;
    bus_phase     = PH_IDLE;
    delay_left    = 12'd0;
    bit_idx       = 4'd0;
    shift_byte    = 8'h00;
    rx_last       = 8'h00;
    poll_cnt      = 10'd0;
    scl_q         = 1'b1;
    sda_q         = 1'b1;
    sda_oe_q      = 1'b1;
    ack_sel_q     = 1'b0;
    ack_timeout_q = 1'b0;

    // idle bus after reset, then unknown codes that must leave it untouched
    row = cmd_row(1'b0, CMD_START, 8'h00, 1'b0, 1'b1, 0);
    row.typed = 1'b1;
    dir_rows.push_back(row);
    row = cmd_row(1'b1, CODE_BAD_HI, 8'hff, 1'b1, 1'b0, 0);
    row.typed = 1'b1;
    dir_rows.push_back(row);
    row = cmd_row(1'b1, CODE_BAD_LO, 8'h00, 1'b0, 1'b1, 0);
    row.typed = 1'b1;
    dir_rows.push_back(row);
    // zero unit acts as one, zero poll limit times out on the first high poll
    dir_rows.push_back(cfg_row(CFG_TICKS_PER_UNIT, 10'd0));
    dir_rows.push_back(cfg_row(CFG_ACK_POLL_LIMIT, 10'd0));
    dir_rows.push_back(cmd_row(1'b1, CMD_START, 8'h00, 1'b0, 1'b1, 6));
    dir_rows.push_back(cmd_row(1'b1, CMD_WRITE, 8'hff, 1'b1, 1'b1, 0));
    // stop offered mid-write is ignored
    dir_rows.push_back(cmd_row(1'b1, CMD_STOP, 8'h00, 1'b0, 1'b1, 28));
    dir_rows.push_back(cmd_row(1'b1, CMD_WRITE, 8'h00, 1'b0, 1'b0, 28));
    dir_rows.push_back(cmd_row(1'b1, CMD_WACK, 8'h00, 1'b0, 1'b1, 10));
    dir_rows.push_back(cmd_row(1'b1, CMD_START, 8'h00, 1'b0, 1'b1, 6));
    dir_rows.push_back(cfg_row(CFG_ACK_POLL_LIMIT, 10'd2));
    dir_rows.push_back(cmd_row(1'b1, CMD_WRITE, 8'h5a, 1'b0, 1'b1, 28));
    dir_rows.push_back(cmd_row(1'b1, CMD_WACK, 8'h00, 1'b0, 1'b0, 4));
    dir_rows.push_back(cmd_row(1'b1, CMD_READ, 8'h00, 1'b1, 1'b1, 24));
    dir_rows.push_back(cmd_row(1'b1, CMD_READ, 8'hff, 1'b0, 1'b0, 24));
    dir_rows.push_back(cmd_row(1'b1, CMD_STOP, 8'h00, 1'b0, 1'b1, 6));
    dir_rows.push_back(cmd_row(1'b1, CMD_WACK, 8'h00, 1'b0, 1'b1, 14));
    dir_rows.push_back(cmd_row(1'b1, CMD_WACK, 8'h00, 1'b0, 1'b0, 4));

    plans.push_back('{10'd1, 10'd3, 200, 1'b0});
    plans.push_back('{10'd2, 10'd1, 140, 1'b0});
    plans.push_back('{10'd0, 10'd0, 100, 1'b0});
    plans.push_back('{10'd1, 10'd40, 150, 1'b0});
    plans.push_back('{10'd40, 10'd40, 1, 1'b1});
    plans.push_back('{10'd3, 10'd6, 120, 1'b0});
    plans.push_back('{10'($urandom_range(1, 4)), 10'($urandom_range(0, 10)), 100, 1'b0});

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        settle_bus();
        write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
      end else begin
        push_item(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);
        filler = '0;
        filler.sda_in = dir_rows[i].rq.sda_in;
        repeat (dir_rows[i].idle_after) push_item(filler, 1'b0, BUS_IDLE_LEVELS);
      end
    end

    foreach (plans[p]) begin
      settle_bus();
      write_reg(CFG_TICKS_PER_UNIT, plans[p].unit);
      write_reg(CFG_ACK_POLL_LIMIT, plans[p].limit);
      n = 0;
      // run each setting until the last command has finished
      while (n < plans[p].ticks || bus_phase != PH_IDLE) begin
        if (ticks_sent % 64 == 0) send_gaps = ($urandom_range(0, 3) != 0);
        draw_tick(plans[p].force_start && n == 0, rq);
        push_item(rq, 1'b0, BUS_IDLE_LEVELS);
        n++;
        if (p == 0 && n == 100) long_hold_req = 1'b1;
        if (p == 0 && n == 200) settle_bus();
      end
    end

    settle_bus();
    repeat (10) @(posedge clk_i);

    $display("Covered %0d ticks over %0d settings: %0d commands, %0d reads, %0d ack timeouts.",
             ticks_sent, plans.size() + 2, cmds_taken, reads_done, timeouts_seen);
    $display("Checked %0d result items, %0d of them wrong.", results_seen, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_step.sv
rtl/core/i2c_master_bit_engine_top.sv
bench/i2c_master_bit_engine_top_tb.sv
